/* src/mofr_pkg.sv */
// Shared widths, codes and types of the MIDI output message framer.
package mofr_pkg;

    localparam int PORTS_DEFAULT     = 4;
    localparam int SYSEX_MAX_DEFAULT = 4096;

    localparam int PORT_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int MSG_W      = 24;
    localparam int COUNT_W    = 13;
    localparam int KIND_W     = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    localparam logic [BYTE_W-1:0] SYSEX_START = 8'hF0;
    localparam logic [BYTE_W-1:0] SYSEX_END   = 8'hF7;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_ONE        = 2'd1,
        PH_TWO_FIRST  = 2'd2,
        PH_TWO_SECOND = 2'd3
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SHORT     = 2'd0,
        KIND_EX_OK     = 2'd1,
        KIND_EX_REJECT = 2'd2
    } kind_t;

    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic [MSG_W-1:0]   short_message;
        logic [BYTE_W-1:0]  exclusive_byte;
        logic               exclusive_end;
        logic [COUNT_W-1:0] exclusive_count;
    } step_result_t;

endpackage

/* src/mofr_frame_step.sv */
// One framing step for a single port: next port state and the result item.
module mofr_frame_step #(
    parameter int FILL_W    = 13,
    parameter int SYSEX_MAX = mofr_pkg::SYSEX_MAX_DEFAULT
) (
    input  logic [mofr_pkg::BYTE_W-1:0] midi_byte,
    input  mofr_pkg::phase_t            phase,
    input  logic                        in_exclusive,
    input  logic [mofr_pkg::MSG_W-1:0]  acc,
    input  logic [FILL_W-1:0]           fill,
    output mofr_pkg::phase_t            phase_next,
    output logic                        in_exclusive_next,
    output logic [mofr_pkg::MSG_W-1:0]  acc_next,
    output logic [FILL_W-1:0]           fill_next,
    output mofr_pkg::step_result_t      result
);
    import mofr_pkg::*;

    logic              ex_path;
    logic              ex_end;
    logic              full;
    logic [FILL_W-1:0] fill_inc;
    logic [FILL_W-1:0] count_src;
    logic [31:0]       count_wide;

    // Data bytes a status byte opens while idle; zero means it goes alone.
    function automatic logic [1:0] data_needed(input logic [BYTE_W-1:0] b);
        logic [1:0] n;
        n = 2'd0;
        case (b[7:4])
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = 2'd2;
            4'hC, 4'hD:                   n = 2'd1;
            4'hF:
            begin
                if (b[3:0] == 4'h2)
                    n = 2'd2;
                else if (b[3:0] == 4'h1 || b[3:0] == 4'h3)
                    n = 2'd1;
            end
            default:                      n = 2'd0;
        endcase
        return n;
    endfunction

    assign ex_path    = in_exclusive || (midi_byte == SYSEX_START);
    assign ex_end     = (midi_byte == SYSEX_END);
    assign full       = (32'(fill) >= 32'(SYSEX_MAX));
    assign fill_inc   = fill + 1'b1;
    assign count_src  = full ? fill : fill_inc;
    assign count_wide = 32'(count_src);

    always_comb
    begin
        phase_next        = phase;
        in_exclusive_next = in_exclusive;
        acc_next          = acc;
        fill_next         = fill;
        result            = '0;
        result.kind       = KIND_SHORT;

        if (ex_path)
        begin
            result.valid           = 1'b1;
            result.kind            = full ? KIND_EX_REJECT : KIND_EX_OK;
            result.exclusive_byte  = midi_byte;
            result.exclusive_end   = ex_end;
            result.exclusive_count = count_wide[COUNT_W-1:0];
            // F7 closes the message even when the buffer is full
            in_exclusive_next      = !ex_end;
            fill_next              = ex_end ? '0 : count_src;
        end
        else
        begin
            case (phase)
                PH_ONE:
                begin
                    acc_next             = {8'h00, midi_byte, acc[7:0]};
                    phase_next           = PH_IDLE;
                    result.valid         = 1'b1;
                    result.short_message = {8'h00, midi_byte, acc[7:0]};
                end
                PH_TWO_FIRST:
                begin
                    acc_next   = {8'h00, midi_byte, acc[7:0]};
                    phase_next = PH_TWO_SECOND;
                end
                PH_TWO_SECOND:
                begin
                    acc_next             = {midi_byte, acc[15:0]};
                    phase_next           = PH_IDLE;
                    result.valid         = 1'b1;
                    result.short_message = {midi_byte, acc[15:0]};
                end
                default:
                begin
                    acc_next = {16'h0000, midi_byte};
                    case (data_needed(midi_byte))
                        2'd2:    phase_next = PH_TWO_FIRST;
                        2'd1:    phase_next = PH_ONE;
                        default:
                        begin
                            phase_next           = PH_IDLE;
                            result.valid         = 1'b1;
                            result.short_message = {16'h0000, midi_byte};
                        end
                    endcase
                end
            endcase
        end
    end

endmodule

/* src/midi_out_message_framer.sv */
// Top level of the per-port MIDI output message framer.
// Takes one MIDI byte per cycle, tagged with an output port, and frames it
// against that port's state: channel and system common messages come out as
// one packed short message once their data bytes arrive, other system bytes
// and stray data bytes come out alone, and exclusive bytes come out one item
// each with a running count (rejected past SYSEX_MAX, F7 always closes the
// message). A byte that completes nothing gives no result item. Throughput is
// one item per cycle on any mix of ports, including the same port back to
// back, while the output does not stall; the result item is registered from
// the input register once the result register is free. The rate is set by the
// per-port state flops, read and written as an item passes from the input
// register to the result register. Bytes for a port at or above PORTS are
// dropped. Reset clears all port state at once; there is no clearing pass.
module midi_out_message_framer #(
    parameter int PORTS     = mofr_pkg::PORTS_DEFAULT,
    parameter int SYSEX_MAX = mofr_pkg::SYSEX_MAX_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] port, [9:2] midi_byte, [15:10] zero
    input  logic [mofr_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] out_port, [25:2] short_message, [33:26] exclusive_byte,
    // [46:34] exclusive_count, [47] zero
    output logic [mofr_pkg::OUT_DATA_W-1:0] m_tdata,
    // [1:0] out_kind
    output logic [mofr_pkg::KIND_W-1:0]     m_tuser,
    // exclusive_end
    output logic                            m_tlast
);
    import mofr_pkg::*;

    localparam int PORT_SPAN = 1 << PORT_W;
    localparam int DEPTH     = (PORTS < PORT_SPAN) ? PORTS : PORT_SPAN;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W    = $clog2(SYSEX_MAX + 1);

    // Input register
    logic              in_valid_reg;
    logic [PORT_W-1:0] in_port_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Per-port framing state
    phase_t            phase_reg [DEPTH];
    logic              in_ex_reg [DEPTH];
    logic [MSG_W-1:0]  acc_reg   [DEPTH];
    logic [FILL_W-1:0] fill_reg  [DEPTH];

    // Result register
    logic              out_valid_reg;
    logic [PORT_W-1:0] out_port_reg;
    step_result_t      out_reg;

    logic [IDX_W-1:0]  idx;
    logic              in_range;
    logic              step_valid;
    logic              out_free;
    logic              advance;

    phase_t            phase_next;
    logic              in_ex_next;
    logic [MSG_W-1:0]  acc_next;
    logic [FILL_W-1:0] fill_next;
    step_result_t      step_result;

    assign idx      = in_port_reg[IDX_W-1:0];
    assign in_range = (32'(in_port_reg) < 32'(PORTS));

    mofr_frame_step #(
        .FILL_W    (FILL_W),
        .SYSEX_MAX (SYSEX_MAX)
    ) u_step (
        .midi_byte         (in_byte_reg),
        .phase             (phase_reg[idx]),
        .in_exclusive      (in_ex_reg[idx]),
        .acc               (acc_reg[idx]),
        .fill              (fill_reg[idx]),
        .phase_next        (phase_next),
        .in_exclusive_next (in_ex_next),
        .acc_next          (acc_next),
        .fill_next         (fill_next),
        .result            (step_result)
    );

    assign step_valid = in_range && step_result.valid;
    assign out_free   = !out_valid_reg || m_tready;
    // An item with no result leaves the input register even when output stalls
    assign advance    = in_valid_reg && (!step_valid || out_free);
    assign s_tready   = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_port_reg <= s_tdata[PORT_W-1:0];
            in_byte_reg <= s_tdata[PORT_W+BYTE_W-1:PORT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                phase_reg[i] <= PH_IDLE;
                in_ex_reg[i] <= 1'b0;
                acc_reg[i]   <= '0;
                fill_reg[i]  <= '0;
            end
        end
        else if (advance && in_range)
        begin
            phase_reg[idx] <= phase_next;
            in_ex_reg[idx] <= in_ex_next;
            acc_reg[idx]   <= acc_next;
            fill_reg[idx]  <= fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && step_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_valid)
        begin
            out_port_reg <= in_port_reg;
            out_reg      <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.exclusive_count, out_reg.exclusive_byte,
                       out_reg.short_message, out_port_reg};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.exclusive_end;

`ifndef SYNTHESIS
    a_ready_low_only_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready)
    ) else $error("input stalled without an output stall");

    a_result_from_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg)
    ) else $error("result appeared without a registered input item");

    a_short_has_no_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_SHORT) |->
            (!m_tlast && out_reg.exclusive_byte == '0 && out_reg.exclusive_count == '0)
    ) else $error("short message carries exclusive fields");

    a_fill_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        32'(fill_reg[0]) <= 32'(SYSEX_MAX)
    ) else $error("exclusive fill beyond limit");

    a_exclusive_has_no_short: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_EX_OK || m_tuser == KIND_EX_REJECT)) |->
            (out_reg.short_message == '0)
    ) else $error("exclusive item carries a short message");
`endif

endmodule

/* verif/midi_out_message_framer_tb.sv */
// Testbench for the MIDI output message framer: directed and random bytes, per-port predictor.
module midi_out_message_framer_tb;
    import mofr_pkg::*;

    localparam int PORTS       = PORTS_DEFAULT;
    localparam int SYSEX_MAX   = SYSEX_MAX_DEFAULT;
    localparam int CYCLE_LIMIT = 800000;

    // status nibbles, system common bytes that take data, and the reset byte
    localparam logic [3:0] ST_NOTE_OFF         = 4'h8;
    localparam logic [3:0] ST_NOTE_ON          = 4'h9;
    localparam logic [3:0] ST_POLY_PRESSURE    = 4'hA;
    localparam logic [3:0] ST_CONTROL          = 4'hB;
    localparam logic [3:0] ST_PROGRAM          = 4'hC;
    localparam logic [3:0] ST_CHANNEL_PRESSURE = 4'hD;
    localparam logic [3:0] ST_PITCH_BEND       = 4'hE;
    localparam logic [3:0] ST_SYSTEM           = 4'hF;
    localparam logic [7:0] TIME_CODE           = 8'hF1;
    localparam logic [7:0] SONG_POSITION       = 8'hF2;
    localparam logic [7:0] SONG_SELECT         = 8'hF3;
    localparam logic [7:0] RESET_BYTE          = 8'hFF;

    typedef struct packed {
        logic [PORT_W-1:0]  port;
        kind_t              kind;
        logic [MSG_W-1:0]   short_message;
        logic [BYTE_W-1:0]  exclusive_byte;
        logic               exclusive_end;
        logic [COUNT_W-1:0] exclusive_count;
    } frame_t;

    class framer_scoreboard;
        phase_t            phase_q [PORTS];
        bit                exclusive_q [PORTS];
        logic [MSG_W-1:0]  accum_q [PORTS];
        int unsigned       fill_q [PORTS];
        frame_t            expected_frames [$];
        int                errors;
        int                bytes_seen;
        int                short_count;
        int                ex_ok_count;
        int                ex_reject_count;

        function new();
            for (int i = 0; i < PORTS; i++) begin
                phase_q[i]     = PH_IDLE;
                exclusive_q[i] = 1'b0;
                accum_q[i]     = '0;
                fill_q[i]      = 0;
            end
            errors = 0;
            bytes_seen = 0;
            short_count = 0;
            ex_ok_count = 0;
            ex_reject_count = 0;
        endfunction

        function int data_bytes_for(logic [7:0] b);
            case (b[7:4])
                ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESSURE, ST_CONTROL, ST_PITCH_BEND:
                    return 2;
                ST_PROGRAM, ST_CHANNEL_PRESSURE:
                    return 1;
                ST_SYSTEM:
                begin
                    if (b == SONG_POSITION)
                        return 2;
                    if (b == TIME_CODE || b == SONG_SELECT)
                        return 1;
                    return 0;
                end
                default:
                    return 0;
            endcase
        endfunction

        function int unsigned fill_of(logic [PORT_W-1:0] p);
            return fill_q[p];
        endfunction

        function bit in_exclusive(logic [PORT_W-1:0] p);
            return exclusive_q[p];
        endfunction

        function int outstanding();
            return expected_frames.size();
        endfunction

        // Advance the port's framing state by one accepted byte.
        function void note_byte(logic [PORT_W-1:0] p, logic [7:0] b);
            frame_t f;
            int     need;
            f = '0;
            f.port = p;
            bytes_seen++;
            if (int'(p) >= PORTS)
                return;
            if (exclusive_q[p] || b == SYSEX_START) begin
                exclusive_q[p] = 1'b1;
                f.exclusive_byte = b;
                f.exclusive_end  = (b == SYSEX_END);
                if (fill_q[p] >= SYSEX_MAX) begin
                    f.kind = KIND_EX_REJECT;
                end else begin
                    fill_q[p]++;
                    f.kind = KIND_EX_OK;
                end
                f.exclusive_count = COUNT_W'(fill_q[p]);
                if (f.exclusive_end) begin
                    exclusive_q[p] = 1'b0;
                    fill_q[p] = 0;
                end
                expected_frames.push_back(f);
                return;
            end
            f.kind = KIND_SHORT;
            case (phase_q[p])
                PH_ONE:
                begin
                    accum_q[p] = {8'h00, b, accum_q[p][7:0]};
                    phase_q[p] = PH_IDLE;
                    f.short_message = accum_q[p];
                    expected_frames.push_back(f);
                end
                PH_TWO_FIRST:
                begin
                    accum_q[p] = {8'h00, b, accum_q[p][7:0]};
                    phase_q[p] = PH_TWO_SECOND;
                end
                PH_TWO_SECOND:
                begin
                    accum_q[p] = {b, accum_q[p][15:0]};
                    phase_q[p] = PH_IDLE;
                    f.short_message = accum_q[p];
                    expected_frames.push_back(f);
                end
                default:
                begin
                    accum_q[p] = {16'h0000, b};
                    need = data_bytes_for(b);
                    if (need == 2) begin
                        phase_q[p] = PH_TWO_FIRST;
                    end else if (need == 1) begin
                        phase_q[p] = PH_ONE;
                    end else begin
                        phase_q[p] = PH_IDLE;
                        f.short_message = accum_q[p];
                        expected_frames.push_back(f);
                    end
                end
            endcase
        endfunction

        function void check_result(logic [PORT_W-1:0] p, logic [KIND_W-1:0] kind,
                                   logic [MSG_W-1:0] msg, logic [7:0] xb, logic xe,
                                   logic [COUNT_W-1:0] xc);
            frame_t e;
            if (expected_frames.size() == 0) begin
                $error("result item with none expected: port %0d kind %0d", p, kind);
                errors++;
                return;
            end
            e = expected_frames.pop_front();
            case (e.kind)
                KIND_SHORT:  short_count++;
                KIND_EX_OK:  ex_ok_count++;
                default:     ex_reject_count++;
            endcase
            if (p !== e.port) begin
                $error("out_port expected %0d got %0d", e.port, p);
                errors++;
            end
            if (kind !== e.kind) begin
                $error("out_kind expected %0d got %0d", e.kind, kind);
                errors++;
            end
            if (msg !== e.short_message) begin
                $error("short_message expected %06h got %06h", e.short_message, msg);
                errors++;
            end
            if (xb !== e.exclusive_byte) begin
                $error("exclusive_byte expected %02h got %02h", e.exclusive_byte, xb);
                errors++;
            end
            if (xe !== e.exclusive_end) begin
                $error("exclusive_end expected %0d got %0d", e.exclusive_end, xe);
                errors++;
            end
            if (xc !== e.exclusive_count) begin
                $error("exclusive_count expected %0d got %0d", e.exclusive_count, xc);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;

    framer_scoreboard sb;
    logic [7:0]       script [PORTS][$];
    int               send_gap_max;
    int               recv_gap_max;
    int               hold_request;
    int               cycle_count;

    midi_out_message_framer #(
        .PORTS     (PORTS),
        .SYSEX_MAX (SYSEX_MAX)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("midi_out_message_framer: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata[1:0], s_tdata[9:2]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[1:0], m_tuser, m_tdata[25:2], m_tdata[33:26],
                                m_tlast, m_tdata[46:34]);
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (hold_request > 0) begin
                m_tready <= 1'b0;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
            end else begin
                gap = $urandom_range(0, recv_gap_max);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Offer one item and hold it until accepted; returns at a falling edge.
    task automatic send_byte(input logic [PORT_W-1:0] p, input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b000000, b, p};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_bytes(input logic [PORT_W-1:0] p, input logic [7:0] seq [$]);
        foreach (seq[i])
            send_byte(p, seq[i]);
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] data_byte();
        // now and then a status byte lands where data is expected
        if ($urandom_range(0, 19) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    // Queue one more message (or some noise) for a port.
    function automatic void queue_message(input logic [PORT_W-1:0] p);
        int         pick;
        int         n;
        logic [7:0] st;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            st = {4'($urandom_range(ST_NOTE_OFF, ST_PITCH_BEND)), 4'($urandom_range(0, 15))};
            script[p].push_back(st);
            n = sb.data_bytes_for(st);
            repeat (n) script[p].push_back(data_byte());
        end else if (pick < 50) begin
            st = 8'($urandom_range(TIME_CODE, SONG_SELECT));
            script[p].push_back(st);
            n = sb.data_bytes_for(st);
            repeat (n) script[p].push_back(data_byte());
        end else if (pick < 62) begin
            script[p].push_back(SYSEX_START);
            n = $urandom_range(0, 12);
            repeat (n)
                script[p].push_back(($urandom_range(0, 15) == 0) ? SYSEX_START : data_byte());
            script[p].push_back(SYSEX_END);
        end else if (pick < 72) begin
            script[p].push_back(8'($urandom_range(8'hF4, RESET_BYTE)));
        end else if (pick < 80) begin
            script[p].push_back(8'($urandom_range(0, 127)));
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) script[p].push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic random_step(input logic [PORT_W-1:0] p);
        logic [7:0] b;
        if (script[p].size() == 0)
            queue_message(p);
        b = script[p].pop_front();
        send_byte(p, b);
    endtask

    task automatic random_run(input int count);
        repeat (count) random_step(PORT_W'($urandom_range(0, PORTS - 1)));
    endtask

    // Fill one port's exclusive buffer past its limit, then close it.
    task automatic overflow_port(input logic [PORT_W-1:0] p);
        logic [7:0] b;
        while (script[p].size() != 0)
            random_step(p);
        if (!sb.in_exclusive(p))
            send_byte(p, SYSEX_START);
        while (sb.fill_of(p) < SYSEX_MAX) begin
            if ($urandom_range(0, 7) == 0)
                random_step(PORT_W'(p + $urandom_range(1, PORTS - 1)));
            b = 8'($urandom_range(0, 255));
            if (b == SYSEX_END)
                b = SYSEX_START;
            send_byte(p, b);
        end
        send_byte(p, data_byte());
        send_byte(p, SYSEX_START);
        send_byte(p, 8'($urandom_range(0, 255)) & 8'h7F);
        send_byte(p, SYSEX_END);
    endtask

    initial
    begin
        logic [7:0]        seq [$];
        logic [PORT_W-1:0] full_port;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cycle_count = 0;
        hold_request = 0;
        send_gap_max = 10;
        recv_gap_max = 10;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // field extremes and two-data channel message
        seq = '{{ST_NOTE_OFF, 4'h0}, 8'h00, 8'h7F};
        send_bytes(2'd0, seq);
        seq = '{{ST_PROGRAM, 4'hF}, 8'h7F};
        send_bytes(2'd1, seq);
        seq = '{SONG_POSITION, 8'h01, 8'h02};
        send_bytes(2'd2, seq);
        seq = '{TIME_CODE, 8'h55};
        send_bytes(2'd3, seq);
        seq = '{SONG_SELECT, RESET_BYTE};
        send_bytes(2'd0, seq);
        // lone system byte, stray data, end-of-exclusive outside exclusive
        seq = '{RESET_BYTE, 8'h00, SYSEX_END};
        send_bytes(2'd3, seq);
        // pending message frozen across an exclusive message, start byte inside it
        seq = '{{ST_NOTE_ON, 4'h3}, 8'h10, SYSEX_START, 8'h41, SYSEX_START, SYSEX_END, 8'h20};
        send_bytes(2'd1, seq);
        // status bytes taken as data while waiting
        seq = '{{ST_CONTROL, 4'h0}, {ST_NOTE_ON, 4'h0}, RESET_BYTE};
        send_bytes(2'd2, seq);
        s_tvalid <= 1'b0;
        wait_drained();

        random_run(400);

        // long result stall while input keeps coming, then drain fully
        hold_request = 300;
        send_gap_max = 0;
        random_run(60);
        s_tvalid <= 1'b0;
        send_gap_max = 10;
        wait_drained();

        send_gap_max = 0;
        recv_gap_max = 0;
        random_run(300);
        send_gap_max = 10;
        recv_gap_max = 10;

        full_port = PORT_W'($urandom_range(0, PORTS - 1));
        overflow_port(full_port);

        random_run(400);
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (10) @(negedge clk);

        $display("%0d bytes sent: %0d short messages, %0d exclusive bytes passed, %0d rejected",
                 sb.bytes_seen, sb.short_count, sb.ex_ok_count, sb.ex_reject_count);
        $display("long output stall exercised; exclusive buffer overflowed on port %0d",
                 full_port);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("midi_out_message_framer: match");
        else
            $display("midi_out_message_framer: mismatch");
        $finish;
    end

endmodule

/* sim.f */
src/mofr_pkg.sv
src/mofr_frame_step.sv
src/midi_out_message_framer.sv
verif/midi_out_message_framer_tb.sv
